FILE: rtl/rfbw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rotated RGB frame buffer writer.
// No dependencies; used by every module under rtl/.
package rfbw_pkg;

   localparam int CANVAS_WIDTH_DEF  = 64;
   localparam int CANVAS_HEIGHT_DEF = 32;

   localparam int COLOR_W     = 8;
   localparam int PIXEL_W     = 3 * COLOR_W;
   localparam int COORD_W     = 16;
   localparam int FUNC_W      = 3;
   localparam int COUNT_W     = 12;
   localparam int COUNT_MAX   = 4095;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [COLOR_W-1:0] BRIGHTNESS_RST = 8'hFF;
   localparam logic [1:0]         ROTATION_RST   = 2'd0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 3'd0,
      FUNC_READ  = 3'd1,
      FUNC_HLINE = 3'd2,
      FUNC_VLINE = 3'd3,
      FUNC_FILL  = 3'd4
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BRIGHTNESS = 4'd0,
      CSR_ROTATION   = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] brightness;
      logic [1:0]         rotation;
   } cfg_type;

endpackage

FILE: rtl/rfbw_store.sv
`timescale 1ns / 1ps
// Single-port pixel memory, one write or one read per cycle, registered read data.
// Depends on rfbw_pkg for the pixel width.
module rfbw_store #(
   parameter int DEPTH  = rfbw_pkg::CANVAS_WIDTH_DEF * rfbw_pkg::CANVAS_HEIGHT_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic                         re,
   input  logic [ADDR_W-1:0]            addr,
   input  logic [rfbw_pkg::PIXEL_W-1:0] wdata,
   output logic [rfbw_pkg::PIXEL_W-1:0] rdata
);

   logic [rfbw_pkg::PIXEL_W-1:0] mem_ff [DEPTH];
   logic [rfbw_pkg::PIXEL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/rfbw_seq.sv
`timescale 1ns / 1ps
// Command sequencer: colour scaling, clipping, rotation mapping and the
// pixel walk over the store. Depends on rfbw_pkg; drives rfbw_store.
module rfbw_seq #(
   parameter int CANVAS_WIDTH  = rfbw_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = rfbw_pkg::CANVAS_HEIGHT_DEF,
   parameter int DEPTH         = CANVAS_WIDTH * CANVAS_HEIGHT,
   parameter int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rfbw_pkg::cfg_type                   cfg,
   input  logic                                start,
   output logic                                busy,
   input  logic [rfbw_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [rfbw_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [rfbw_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [rfbw_pkg::COORD_W-1:0] req_span,
   input  logic [rfbw_pkg::COLOR_W-1:0]        req_red,
   input  logic [rfbw_pkg::COLOR_W-1:0]        req_green,
   input  logic [rfbw_pkg::COLOR_W-1:0]        req_blue,
   output logic                                mem_we,
   output logic                                mem_re,
   output logic [ADDR_W-1:0]                   mem_addr,
   output logic [rfbw_pkg::PIXEL_W-1:0]        mem_wdata,
   input  logic [rfbw_pkg::PIXEL_W-1:0]        mem_rdata,
   output logic                                rsp_valid,
   output logic [rfbw_pkg::COLOR_W-1:0]        rsp_read_red,
   output logic [rfbw_pkg::COLOR_W-1:0]        rsp_read_green,
   output logic [rfbw_pkg::COLOR_W-1:0]        rsp_read_blue,
   output logic [rfbw_pkg::COUNT_W-1:0]        rsp_pixels_written
);

   localparam int DIM_MAX    = (CANVAS_WIDTH > CANVAS_HEIGHT) ? CANVAS_WIDTH : CANVAS_HEIGHT;
   localparam int CRD_W      = $clog2(DIM_MAX + 1);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int RNG_W      = rfbw_pkg::COORD_W + 2;
   localparam int CW         = rfbw_pkg::COLOR_W;
   localparam int FILL_COUNT = (DEPTH > rfbw_pkg::COUNT_MAX) ? rfbw_pkg::COUNT_MAX : DEPTH;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_CLIP,
      ST_MAP,
      ST_ADDR,
      ST_RUN,
      ST_READ,
      ST_READ_DONE
   } state_type;

   state_type                             state_ff, state_in;
   rfbw_pkg::func_type                    op_ff, op_in;
   logic signed [rfbw_pkg::COORD_W-1:0]   x_ff, x_in, y_ff, y_in, span_ff, span_in;
   logic [CW-1:0]                         red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [rfbw_pkg::PIXEL_W-1:0]          colour_ff, colour_in;
   logic                                  horiz_ff, horiz_in;
   logic signed [RNG_W-1:0]               a_raw_ff, a_raw_in, b_raw_ff, b_raw_in;
   logic                                  fixed_ok_ff, fixed_ok_in;
   logic [CRD_W-1:0]                      fixed_ff, fixed_in;
   logic [CRD_W-1:0]                      a_clip_ff, a_clip_in, len_ff, len_in;
   logic                                  line_ok_ff, line_ok_in;
   logic [CRD_W-1:0]                      px_ff, px_in, py_ff, py_in;
   logic [ADDR_W-1:0]                     idx_ff, idx_in;
   logic [CNT_W-1:0]                      remain_ff, remain_in;
   logic                                  step_big_ff, step_big_in, step_neg_ff, step_neg_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                         rsp_red_ff, rsp_red_in;
   logic [CW-1:0]                         rsp_green_ff, rsp_green_in;
   logic [CW-1:0]                         rsp_blue_ff, rsp_blue_in;
   logic [rfbw_pkg::COUNT_W-1:0]          rsp_count_ff, rsp_count_in;

   // logical canvas size under the current rotation
   logic [CRD_W-1:0] log_w, log_h;
   assign log_w = cfg.rotation[0] ? CRD_W'(CANVAS_HEIGHT) : CRD_W'(CANVAS_WIDTH);
   assign log_h = cfg.rotation[0] ? CRD_W'(CANVAS_WIDTH)  : CRD_W'(CANVAS_HEIGHT);

   // CALC stage: scale, line range before clipping, cross-axis check
   logic [CW:0]                         bright1;
   logic [2*CW:0]                       prod_r, prod_g, prod_b;
   logic                                horiz_c, single_c;
   logic signed [rfbw_pkg::COORD_W-1:0] start_c, fixed_c, span_c;
   logic signed [RNG_W-1:0]             start_ext, span_ext;
   logic [CRD_W-1:0]                    flim_c;
   logic                                fixed_ok_c;

   assign bright1 = {1'b0, cfg.brightness} + (CW + 1)'(1);
   assign prod_r  = (2*CW + 1)'(red_ff)   * (2*CW + 1)'(bright1);
   assign prod_g  = (2*CW + 1)'(green_ff) * (2*CW + 1)'(bright1);
   assign prod_b  = (2*CW + 1)'(blue_ff)  * (2*CW + 1)'(bright1);

   assign horiz_c   = (op_ff != rfbw_pkg::FUNC_VLINE);
   assign single_c  = (op_ff == rfbw_pkg::FUNC_WRITE) || (op_ff == rfbw_pkg::FUNC_READ);
   assign start_c   = horiz_c ? x_ff : y_ff;
   assign fixed_c   = horiz_c ? y_ff : x_ff;
   assign span_c    = single_c ? rfbw_pkg::COORD_W'(1) : span_ff;
   assign start_ext = {{2{start_c[rfbw_pkg::COORD_W-1]}}, start_c};
   assign span_ext  = {{2{span_c[rfbw_pkg::COORD_W-1]}}, span_c};
   assign flim_c    = horiz_c ? log_h : log_w;
   assign fixed_ok_c = !fixed_c[rfbw_pkg::COORD_W-1]
                     && (fixed_c[rfbw_pkg::COORD_W-2:0] < (rfbw_pkg::COORD_W - 1)'(flim_c));

   // CLIP stage
   logic [CRD_W-1:0]        lim_c;
   logic signed [RNG_W-1:0] lim_s, a_c, b_c, diff_c;

   assign lim_c  = horiz_ff ? log_w : log_h;
   assign lim_s  = $signed(RNG_W'(lim_c));
   assign a_c    = (a_raw_ff < 0) ? '0 : a_raw_ff;
   assign b_c    = (b_raw_ff > lim_s) ? lim_s : b_raw_ff;
   assign diff_c = b_c - a_c;

   // MAP stage: logical to physical
   logic [CRD_W-1:0] lx_c, ly_c, px_c, py_c;
   assign lx_c = horiz_ff ? a_clip_ff : fixed_ff;
   assign ly_c = horiz_ff ? fixed_ff  : a_clip_ff;

   always_comb begin
      case (cfg.rotation)
         2'd1: begin
            px_c = CRD_W'(CANVAS_WIDTH - 1) - ly_c;
            py_c = lx_c;
         end
         2'd2: begin
            px_c = CRD_W'(CANVAS_WIDTH - 1) - lx_c;
            py_c = CRD_W'(CANVAS_HEIGHT - 1) - ly_c;
         end
         2'd3: begin
            px_c = ly_c;
            py_c = CRD_W'(CANVAS_HEIGHT - 1) - lx_c;
         end
         default: begin
            px_c = lx_c;
            py_c = ly_c;
         end
      endcase
   end

   // ADDR stage and walk
   logic [ADDR_W-1:0] idx_calc, step_val, idx_next;
   assign idx_calc = ADDR_W'(32'(py_ff) * 32'(CANVAS_WIDTH) + 32'(px_ff));
   assign step_val = step_big_ff ? ADDR_W'(CANVAS_WIDTH) : ADDR_W'(1);
   assign idx_next = step_neg_ff ? (idx_ff - step_val) : (idx_ff + step_val);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      span_in      = span_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      colour_in    = colour_ff;
      horiz_in     = horiz_ff;
      a_raw_in     = a_raw_ff;
      b_raw_in     = b_raw_ff;
      fixed_ok_in  = fixed_ok_ff;
      fixed_in     = fixed_ff;
      a_clip_in    = a_clip_ff;
      len_in       = len_ff;
      line_ok_in   = line_ok_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      idx_in       = idx_ff;
      remain_in    = remain_ff;
      step_big_in  = step_big_ff;
      step_neg_in  = step_neg_ff;
      rsp_valid_in = 1'b0;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wdata    = colour_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            idx_in    = idx_ff + ADDR_W'(1);
            if (idx_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = rfbw_pkg::func_type'(req_func);
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               span_in  = req_span;
               red_in   = req_red;
               green_in = req_green;
               blue_in  = req_blue;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            colour_in   = {prod_r[2*CW-1:CW], prod_g[2*CW-1:CW], prod_b[2*CW-1:CW]};
            horiz_in    = horiz_c;
            fixed_ok_in = fixed_ok_c;
            fixed_in    = CRD_W'(fixed_c);
            if (!span_c[rfbw_pkg::COORD_W-1]) begin
               a_raw_in = start_ext;
               b_raw_in = start_ext + span_ext;
            end else begin
               a_raw_in = start_ext + RNG_W'(1) + span_ext;
               b_raw_in = start_ext + RNG_W'(1);
            end
            case (op_ff)
               rfbw_pkg::FUNC_FILL: begin
                  idx_in      = '0;
                  remain_in   = CNT_W'(DEPTH);
                  step_big_in = 1'b0;
                  step_neg_in = 1'b0;
                  state_in    = ST_RUN;
               end
               rfbw_pkg::FUNC_WRITE, rfbw_pkg::FUNC_READ,
               rfbw_pkg::FUNC_HLINE, rfbw_pkg::FUNC_VLINE: begin
                  state_in = ST_CLIP;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_red_in   = '0;
                  rsp_green_in = '0;
                  rsp_blue_in  = '0;
                  rsp_count_in = '0;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_CLIP: begin
            a_clip_in  = CRD_W'(a_c);
            len_in     = CRD_W'(diff_c);
            line_ok_in = fixed_ok_ff && (a_c < b_c);
            state_in   = ST_MAP;
         end
         ST_MAP: begin
            px_in    = px_c;
            py_in    = py_c;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            idx_in      = idx_calc;
            remain_in   = CNT_W'(len_ff);
            step_big_in = horiz_ff ? cfg.rotation[0] : !cfg.rotation[0];
            step_neg_in = horiz_ff ? cfg.rotation[1] : (cfg.rotation[0] ^ cfg.rotation[1]);
            if (line_ok_ff) begin
               state_in = (op_ff == rfbw_pkg::FUNC_READ) ? ST_READ : ST_RUN;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = '0;
               rsp_green_in = '0;
               rsp_blue_in  = '0;
               rsp_count_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_RUN: begin
            mem_we    = 1'b1;
            idx_in    = idx_next;
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = '0;
               rsp_green_in = '0;
               rsp_blue_in  = '0;
               rsp_count_in = (op_ff == rfbw_pkg::FUNC_FILL) ?
                              rfbw_pkg::COUNT_W'(FILL_COUNT) : rfbw_pkg::COUNT_W'(len_ff);
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_READ_DONE;
         end
         ST_READ_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_red_in   = mem_rdata[3*CW-1:2*CW];
            rsp_green_in = mem_rdata[2*CW-1:CW];
            rsp_blue_in  = mem_rdata[CW-1:0];
            rsp_count_in = '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      span_ff      <= span_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      colour_ff    <= colour_in;
      horiz_ff     <= horiz_in;
      a_raw_ff     <= a_raw_in;
      b_raw_ff     <= b_raw_in;
      fixed_ok_ff  <= fixed_ok_in;
      fixed_ff     <= fixed_in;
      a_clip_ff    <= a_clip_in;
      len_ff       <= len_in;
      line_ok_ff   <= line_ok_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      remain_ff    <= remain_in;
      step_big_ff  <= step_big_in;
      step_neg_ff  <= step_neg_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign mem_addr           = idx_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_red       = rsp_red_ff;
   assign rsp_read_green     = rsp_green_ff;
   assign rsp_read_blue      = rsp_blue_ff;
   assign rsp_pixels_written = rsp_count_ff;

endmodule

FILE: rtl/rotated_rgb_framebuffer_writer.sv
`timescale 1ns / 1ps
// Top level of the rotated RGB frame buffer writer: CSR registers, sequencer, store.
// Depends on rfbw_pkg, rfbw_store and rfbw_seq.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------------
//  request   | start / busy          | req_func, req_pos_x, req_pos_y, req_span,
//            |                       | req_red, req_green, req_blue
//  response  | rsp_valid (strobe)    | rsp_read_red/green/blue, rsp_pixels_written
//  csr       | csr_valid / csr_ready | csr_index, csr_wdata
//
// A transaction is taken when start is high and busy is low; busy stays high until the
// response strobe is issued, and the strobe comes in the first cycle busy is low again.
// Each command passes CALC; a fill goes to RUN, others pass CLIP, MAP, ADDR (where a fully
// clipped one ends), then RUN stores one pixel per cycle via the single store port or READ
// and READ_DONE fetch one. After reset the store is swept to zero, one pixel per cycle, with
// busy high, CSR writes taken throughout. Responses cannot stall; csr_ready is always high.
module rotated_rgb_framebuffer_writer #(
   parameter int CANVAS_WIDTH  = rfbw_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = rfbw_pkg::CANVAS_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rfbw_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [rfbw_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [rfbw_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [rfbw_pkg::COORD_W-1:0]  req_span,
   input  logic [rfbw_pkg::COLOR_W-1:0]         req_red,
   input  logic [rfbw_pkg::COLOR_W-1:0]         req_green,
   input  logic [rfbw_pkg::COLOR_W-1:0]         req_blue,
   output logic                                 rsp_valid,
   output logic [rfbw_pkg::COLOR_W-1:0]         rsp_read_red,
   output logic [rfbw_pkg::COLOR_W-1:0]         rsp_read_green,
   output logic [rfbw_pkg::COLOR_W-1:0]         rsp_read_blue,
   output logic [rfbw_pkg::COUNT_W-1:0]         rsp_pixels_written,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfbw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rfbw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // CSR block: always ready, unknown indexes dropped
   logic [rfbw_pkg::COLOR_W-1:0] brightness_ff, brightness_in;
   logic [1:0]                   rotation_ff, rotation_in;
   rfbw_pkg::cfg_type            cfg;

   always_comb begin
      brightness_in = brightness_ff;
      rotation_in   = rotation_ff;
      if (csr_valid) begin
         case (rfbw_pkg::csr_index_type'(csr_index))
            rfbw_pkg::CSR_BRIGHTNESS: brightness_in = csr_wdata[rfbw_pkg::COLOR_W-1:0];
            rfbw_pkg::CSR_ROTATION:   rotation_in   = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= rfbw_pkg::BRIGHTNESS_RST;
         rotation_ff   <= rfbw_pkg::ROTATION_RST;
      end else begin
         brightness_ff <= brightness_in;
         rotation_ff   <= rotation_in;
      end
   end

   assign csr_ready      = 1'b1;
   assign cfg.brightness = brightness_ff;
   assign cfg.rotation   = rotation_ff;

   // store port; accesses never overlap since one command runs at a time
   logic                         mem_we, mem_re;
   logic [ADDR_W-1:0]            mem_addr;
   logic [rfbw_pkg::PIXEL_W-1:0] mem_wdata, mem_rdata;

   rfbw_seq #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT),
      .DEPTH         (DEPTH),
      .ADDR_W        (ADDR_W)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_span           (req_span),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .mem_we             (mem_we),
      .mem_re             (mem_re),
      .mem_addr           (mem_addr),
      .mem_wdata          (mem_wdata),
      .mem_rdata          (mem_rdata),
      .rsp_valid          (rsp_valid),
      .rsp_read_red       (rsp_read_red),
      .rsp_read_green     (rsp_read_green),
      .rsp_read_blue      (rsp_read_blue),
      .rsp_pixels_written (rsp_pixels_written)
   );

   rfbw_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // accepted transaction always leaves the block busy in the cycle after it
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // response is a single-cycle strobe
   a_rsp_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // response only closes a busy period
   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response without a preceding busy period");

   // a command that stored pixels never returns read data
   a_write_no_read : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_pixels_written != '0)) |->
      ((rsp_read_red == '0) && (rsp_read_green == '0) && (rsp_read_blue == '0)))
      else $error("read data on a writing command");

endmodule
